// ----- hw/rtl/tcsnk_pkg.sv -----
// shared types and constants for the try.snk policy block
`default_nettype none

package tcsnk_pkg;

	// widths of the item fields and of the timeout register
	localparam int CFG_W       = 16;
	localparam int STATUS_W    = 8;
	localparam int PMODE_W     = 2;
	localparam int STATE_W     = 4;
	localparam int CURRENT_W   = 12;
	localparam int POL_W       = 2;
	localparam int TIMER_BITS_DEF = 16;

	// reset value of the timeout register
	localparam logic [CFG_W-1:0] TIMEOUT_RST = CFG_W'(200);

	// item kind
	localparam logic KIND_SERVICE = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	// interrupt status that means detach only
	localparam logic [STATUS_W-1:0] INT_DETACH = 8'h02;

	// port modes
	localparam logic [PMODE_W-1:0] PM_SINK   = 2'd0;
	localparam logic [PMODE_W-1:0] PM_SOURCE = 2'd1;
	localparam logic [PMODE_W-1:0] PM_DUAL   = 2'd2;

	// policy states
	localparam logic [STATE_W-1:0] ST_IDLE         = 4'd0;
	localparam logic [STATE_W-1:0] ST_TO_SINK      = 4'd2;
	localparam logic [STATE_W-1:0] ST_WAIT_DETACH  = 4'd3;
	localparam logic [STATE_W-1:0] ST_AS_SINK      = 4'd4;
	localparam logic [STATE_W-1:0] ST_TRY_WAIT_SRC = 4'd6;
	localparam logic [STATE_W-1:0] ST_AS_SOURCE    = 4'd7;
	localparam logic [STATE_W-1:0] ST_AUDIO        = 4'd8;
	localparam logic [STATE_W-1:0] ST_DEBUG        = 4'd9;

	// cc status current codes
	localparam logic [1:0] CUR_1500 = 2'd2;
	localparam logic [1:0] CUR_3000 = 2'd3;

	// cc status attach kinds
	localparam logic [2:0] ATT_SINK  = 3'd1;
	localparam logic [2:0] ATT_SRC   = 3'd2;
	localparam logic [2:0] ATT_AUDIO = 3'd3;
	localparam logic [2:0] ATT_DEBUG = 3'd4;

	// advertised current values in mA
	localparam logic [CURRENT_W-1:0] MA_500  = 12'd500;
	localparam logic [CURRENT_W-1:0] MA_1500 = 12'd1500;
	localparam logic [CURRENT_W-1:0] MA_3000 = 12'd3000;

	// one input item
	typedef struct packed {
		logic                kind;
		logic [STATUS_W-1:0] int_status;
		logic [STATUS_W-1:0] cc_status;
	} item_t;

	// one result item
	typedef struct packed {
		logic                 mode_write;
		logic [PMODE_W-1:0]   port_mode;
		logic [STATE_W-1:0]   try_state;
		logic [CURRENT_W-1:0] max_current_ma;
		logic                 current_update;
		logic [POL_W-1:0]     cc_polarity;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/typec_try_sink_policy.sv -----
// Type-C try.snk policy machine: top level
//
// Input channel (in_valid/in_ready) carries one item: mode 0 is an
// interrupt service with int_status and cc_status, mode 1 is one timer
// tick. Output channel (out_valid/out_ready) gives exactly one result
// per item: mode write request, port mode, policy state, current limit,
// current refresh flag and CC polarity.
// The item is captured in an input register; the policy step is one
// level of logic from that register and the state registers into the
// result register, which drives out_valid and the result fields. One
// item per cycle is sustained while the receiver keeps out_ready high.
// The input stage moves on whenever the result register is empty or
// being taken, so a stalled receiver holds one result and one pending
// item, then drops in_ready until out_ready returns.
// The timeout register is written through cfg_valid/cfg_ready/cfg_data,
// always ready, and is meant to change only while the block is idle.
// Reset (arst_n low) empties both stages, puts the policy in idle
// dual-role mode, stops the timeout and sets the timeout to 200 ticks.
`default_nettype none

module typec_try_sink_policy
	import tcsnk_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input items
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 mode,
	input  wire logic [STATUS_W-1:0]  int_status,
	input  wire logic [STATUS_W-1:0]  cc_status,
	// result items
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      mode_write,
	output logic [PMODE_W-1:0]        port_mode,
	output logic [STATE_W-1:0]        try_state,
	output logic [CURRENT_W-1:0]      max_current_ma,
	output logic                      current_update,
	output logic [POL_W-1:0]          cc_polarity
);

	logic [CFG_W-1:0]      timeout_ticks_q;
	logic                  valid_s1;
	item_t                 item_s1;
	logic                  valid_s2;
	result_t               res_s2;
	logic                  adv_s1;

	logic [STATE_W-1:0]    state_q;
	logic [TIMER_BITS-1:0] count_q;
	logic                  running_q;
	logic [CURRENT_W-1:0]  current_q;
	logic [PMODE_W-1:0]    pmode_q;
	logic [POL_W-1:0]      pol_q;

	logic [STATE_W-1:0]    state_d;
	logic [TIMER_BITS-1:0] count_d;
	logic                  running_d;
	logic [CURRENT_W-1:0]  current_d;
	logic [PMODE_W-1:0]    pmode_d;
	logic [POL_W-1:0]      pol_d;
	logic                  wr_d;
	logic                  upd_d;
	logic [TIMER_BITS-1:0] load_val;
	logic [TIMER_BITS-1:0] count_dec;
	logic [1:0]            cur_code;
	logic [2:0]            att_kind;

	// handshakes
	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			timeout_ticks_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: mode, int_status: int_status, cc_status: cc_status};
		end
	end

	// timeout load value: zero loads one tick, too large saturates
	always_comb begin
		load_val = TIMER_BITS'(timeout_ticks_q);
		if (timeout_ticks_q == '0) begin
			load_val = TIMER_BITS'(1);
		end
		if ((TIMER_BITS < CFG_W) && ((timeout_ticks_q >> TIMER_BITS) != '0)) begin
			load_val = '1;
		end
	end

	assign count_dec = (count_q != '0) ? count_q - TIMER_BITS'(1) : count_q;
	assign cur_code  = item_s1.cc_status[6:5];
	assign att_kind  = item_s1.cc_status[4:2];

	// policy step
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		running_d = running_q;
		current_d = current_q;
		pmode_d   = pmode_q;
		pol_d     = pol_q;
		wr_d      = 1'b0;
		upd_d     = 1'b0;
		if (item_s1.kind == KIND_TICK) begin
			// timer tick
			if (running_q) begin
				count_d = count_dec;
				if (count_dec == '0) begin
					running_d = 1'b0;
					if (state_q == ST_WAIT_DETACH) begin
						pmode_d = PM_SOURCE;
						wr_d    = 1'b1;
						state_d = ST_TRY_WAIT_SRC;
					end
				end
			end
		end else if (item_s1.int_status == INT_DETACH) begin
			// detach only
			if (state_q == ST_AS_SOURCE || state_q == ST_AS_SINK) begin
				pmode_d = PM_DUAL;
				wr_d    = 1'b1;
				state_d = ST_IDLE;
			end else if (state_q == ST_TO_SINK) begin
				state_d = ST_WAIT_DETACH;
				if (!running_q) begin
					running_d = 1'b1;
					count_d   = load_val;
				end
			end
		end else begin
			// attach path: decode cc status
			case (cur_code)
				CUR_1500: current_d = MA_1500;
				CUR_3000: current_d = MA_3000;
				default:  current_d = MA_500;
			endcase
			upd_d = 1'b1;
			pol_d = item_s1.cc_status[1:0];
			unique case (att_kind)
				ATT_SINK: begin
					state_d = ST_AS_SINK;
				end
				ATT_SRC: begin
					if (state_q == ST_IDLE) begin
						pmode_d = PM_SINK;
						wr_d    = 1'b1;
						state_d = ST_TO_SINK;
					end else if (state_q == ST_TRY_WAIT_SRC) begin
						state_d = ST_AS_SOURCE;
					end
				end
				ATT_AUDIO: begin
					state_d = ST_AUDIO;
				end
				ATT_DEBUG: begin
					state_d = ST_DEBUG;
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	// policy state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			running_q <= 1'b0;
			current_q <= '0;
			pmode_q   <= PM_DUAL;
			pol_q     <= '0;
		end else if (adv_s1) begin
			state_q   <= state_d;
			count_q   <= count_d;
			running_q <= running_d;
			current_q <= current_d;
			pmode_q   <= pmode_d;
			pol_q     <= pol_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= '{mode_write: wr_d, port_mode: pmode_d, try_state: state_d,
				max_current_ma: current_d, current_update: upd_d, cc_polarity: pol_d};
		end
	end

	assign out_valid      = valid_s2;
	assign mode_write     = res_s2.mode_write;
	assign port_mode      = res_s2.port_mode;
	assign try_state      = res_s2.try_state;
	assign max_current_ma = res_s2.max_current_ma;
	assign current_update = res_s2.current_update;
	assign cc_polarity    = res_s2.cc_polarity;

`ifndef SYNTHESIS
	// a running timeout never holds a zero count
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (count_q != '0))
		else $error("timeout running with zero count");

	// port mode register never takes the unused code
	a_pmode: assert property (@(posedge clk) disable iff (!arst_n)
		(pmode_q == PM_SINK) || (pmode_q == PM_SOURCE) || (pmode_q == PM_DUAL))
		else $error("illegal port mode");

	// a refreshed current is one of the advertised values
	a_current: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.current_update) |->
		((res_s2.max_current_ma == MA_500) || (res_s2.max_current_ma == MA_1500) ||
		(res_s2.max_current_ma == MA_3000)))
		else $error("bad current value");

	// the state advances only when an item leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

// ----- dv/tcsnk_policy_checker.sv -----
// checker for the try.snk policy block: predicts every result item and compares it with the block
module tcsnk_policy_checker
	import tcsnk_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 mode,
	input  logic [STATUS_W-1:0]  int_status,
	input  logic [STATUS_W-1:0]  cc_status,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 mode_write,
	input  logic [PMODE_W-1:0]   port_mode,
	input  logic [STATE_W-1:0]   try_state,
	input  logic [CURRENT_W-1:0] max_current_ma,
	input  logic                 current_update,
	input  logic [POL_W-1:0]     cc_polarity,
	output int                   fail_count,
	output int                   awaited,
	output int                   reports_seen,
	output int                   mode_writes_seen,
	output logic [15:0]          states_seen
);

	// own copy of the timeout register and of the policy state
	logic [CFG_W-1:0]      timeout_setting;
	logic [STATE_W-1:0]    pstate;
	logic [TIMER_BITS-1:0] ticks_left;
	logic                  timer_on;
	logic [CURRENT_W-1:0]  limit_ma;
	logic [PMODE_W-1:0]    pmode;
	logic [POL_W-1:0]      polarity;

	// reports owed by the block, oldest first
	result_t awaited_reports[$];

	// count loaded when the try timeout starts: zero means one tick, clipped to the counter
	function automatic logic [TIMER_BITS-1:0] timer_load();
		longint unsigned top_count;
		longint unsigned load;
		top_count = (64'd1 << TIMER_BITS) - 1;
		load = timeout_setting;
		if (load == 0)
			load = 1;
		if (load > top_count)
			load = top_count;
		return TIMER_BITS'(load);
	endfunction

	// one policy step: updates the state copy and returns the report it causes
	function automatic result_t step_policy(input item_t it);
		result_t r;
		logic [2:0] att;
		r = '0;
		if (it.kind == KIND_TICK) begin
			// ticks only count down a running timeout; the status bytes are ignored
			if (timer_on) begin
				if (ticks_left != 0)
					ticks_left = ticks_left - 1'b1;
				if (ticks_left == 0) begin
					timer_on = 1'b0;
					if (pstate == ST_WAIT_DETACH) begin
						pmode = PM_SOURCE;
						r.mode_write = 1'b1;
						pstate = ST_TRY_WAIT_SRC;
					end
				end
			end
		end else if (it.int_status == INT_DETACH) begin
			// detach: attached ports go back to dual role, forced sink starts the timeout
			if (pstate == ST_AS_SOURCE || pstate == ST_AS_SINK) begin
				pmode = PM_DUAL;
				r.mode_write = 1'b1;
				pstate = ST_IDLE;
			end else if (pstate == ST_TO_SINK) begin
				pstate = ST_WAIT_DETACH;
				if (!timer_on) begin
					timer_on = 1'b1;
					ticks_left = timer_load();
				end
			end
		end else begin
			// attach path: current, polarity, then the attach kind
			case (it.cc_status[6:5])
				CUR_1500: limit_ma = MA_1500;
				CUR_3000: limit_ma = MA_3000;
				default:  limit_ma = MA_500;
			endcase
			r.current_update = 1'b1;
			polarity = it.cc_status[1:0];
			att = it.cc_status[4:2];
			case (att)
				ATT_SINK: pstate = ST_AS_SINK;
				ATT_SRC: begin
					if (pstate == ST_IDLE) begin
						pmode = PM_SINK;
						r.mode_write = 1'b1;
						pstate = ST_TO_SINK;
					end else if (pstate == ST_TRY_WAIT_SRC) begin
						pstate = ST_AS_SOURCE;
					end
				end
				ATT_AUDIO: pstate = ST_AUDIO;
				ATT_DEBUG: pstate = ST_DEBUG;
				default: ;
			endcase
		end
		r.port_mode = pmode;
		r.try_state = pstate;
		r.max_current_ma = limit_ma;
		r.cc_polarity = polarity;
		return r;
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		item_t   it;
		if (!arst_n) begin
			timeout_setting = TIMEOUT_RST;
			pstate = ST_IDLE;
			ticks_left = '0;
			timer_on = 1'b0;
			limit_ma = '0;
			pmode = PM_DUAL;
			polarity = '0;
			awaited_reports.delete();
			fail_count <= 0;
			awaited <= 0;
			reports_seen <= 0;
			mode_writes_seen <= 0;
			states_seen <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				timeout_setting = cfg_data;

			// compare an accepted report with the oldest one owed
			if (out_valid && out_ready) begin
				got.mode_write = mode_write;
				got.port_mode = port_mode;
				got.try_state = try_state;
				got.max_current_ma = max_current_ma;
				got.current_update = current_update;
				got.cc_polarity = cc_polarity;
				reports_seen <= reports_seen + 1;
				mode_writes_seen <= mode_writes_seen + int'(got.mode_write);
				states_seen[got.try_state] <= 1'b1;
				if (awaited_reports.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item: state %0d mode %0d",
							got.try_state, got.port_mode);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_reports.pop_front();
					if (got.mode_write !== want.mode_write ||
						got.port_mode !== want.port_mode ||
						got.try_state !== want.try_state ||
						got.max_current_ma !== want.max_current_ma ||
						got.current_update !== want.current_update ||
						got.cc_polarity !== want.cc_polarity) begin
						if (fail_count < 10) begin
							$display("bad result item %0d: expected wr %0d mode %0d state %0d ma %0d upd %0d pol %0d",
								reports_seen, want.mode_write, want.port_mode, want.try_state,
								want.max_current_ma, want.current_update, want.cc_polarity);
							$display("                   got      wr %0d mode %0d state %0d ma %0d upd %0d pol %0d",
								got.mode_write, got.port_mode, got.try_state,
								got.max_current_ma, got.current_update, got.cc_polarity);
						end
						fail_count <= fail_count + 1;
					end
				end
			end

			// predict the report for an accepted input item
			if (in_valid && in_ready) begin
				it.kind = mode;
				it.int_status = int_status;
				it.cc_status = cc_status;
				awaited_reports.push_back(step_policy(it));
			end
			awaited <= awaited_reports.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// testbench top for the try.snk policy block: stimulus, receiver stalls and verdict
module tb;
	import tcsnk_pkg::*;

	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS   = 70;

	typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN, RX_WAVE} rx_style_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 mode = KIND_SERVICE;
	logic [STATUS_W-1:0]  int_status = '0;
	logic [STATUS_W-1:0]  cc_status = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 mode_write;
	logic [PMODE_W-1:0]   port_mode;
	logic [STATE_W-1:0]   try_state;
	logic [CURRENT_W-1:0] max_current_ma;
	logic                 current_update;
	logic [POL_W-1:0]     cc_polarity;

	int          fail_count;
	int          awaited;
	int          reports_seen;
	int          mode_writes_seen;
	logic [15:0] states_seen;

	int               burst_left = 0;
	int               items_sent = 0;
	int               quiet_cycles = 0;
	logic [CFG_W-1:0] timeout_now = TIMEOUT_RST;
	rx_style_e        ready_style = RX_OPEN;
	int               style_left = 0;
	int               wave_len = 4;
	int               wave_pos = 0;

	// clock, period 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	typec_try_sink_policy i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.int_status     (int_status),
		.cc_status      (cc_status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mode_write     (mode_write),
		.port_mode      (port_mode),
		.try_state      (try_state),
		.max_current_ma (max_current_ma),
		.current_update (current_update),
		.cc_polarity    (cc_polarity)
	);

	tcsnk_policy_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.int_status       (int_status),
		.cc_status        (cc_status),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mode_write       (mode_write),
		.port_mode        (port_mode),
		.try_state        (try_state),
		.max_current_ma   (max_current_ma),
		.current_update   (current_update),
		.cc_polarity      (cc_polarity),
		.fail_count       (fail_count),
		.awaited          (awaited),
		.reports_seen     (reports_seen),
		.mode_writes_seen (mode_writes_seen),
		.states_seen      (states_seen)
	);

	// receiver: picks a new stall style each time its style counter runs out
	always @(posedge clk) begin
		if (style_left == 0) begin
			ready_style <= rx_style_e'($urandom_range(0, 3));
			style_left <= $urandom_range(20, 80);
			wave_len <= $urandom_range(2, 16);
		end else begin
			style_left <= style_left - 1;
		end
		wave_pos <= wave_pos + 1;
		case (ready_style)
			RX_OPEN:   out_ready <= 1'b1;
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			default:   out_ready <= ((wave_pos / wave_len) % 2) == 0;
		endcase
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("typec_try_sink_policy: mismatch");
			$finish;
		end
	end

	// send one item; bursts of random length with random gaps between them
	task automatic send_item(input logic kind, input logic [7:0] ints, input logic [7:0] cc);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		mode <= kind;
		int_status <= ints;
		cc_status <= cc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// stop sending and wait until every owed result has come
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [CFG_W-1:0] ticks);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		timeout_now = ticks;
	endtask

	// random interrupt status that takes the attach path
	function automatic logic [7:0] event_status();
		logic [7:0] s;
		s = 8'($urandom);
		if (s == INT_DETACH)
			s = ~s;
		return s;
	endfunction

	// random cc status with a given attach kind
	function automatic logic [7:0] cc_with_kind(input logic [2:0] att);
		logic [7:0] cc;
		cc = 8'($urandom);
		cc[4:2] = att;
		return cc;
	endfunction

	task automatic attach(input logic [2:0] att);
		send_item(KIND_SERVICE, event_status(), cc_with_kind(att));
	endtask

	task automatic detach();
		send_item(KIND_SERVICE, INT_DETACH, 8'($urandom));
	endtask

	task automatic tick_run(input int n);
		repeat (n) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
	endtask

	// number of ticks around the expiry; long timeouts get only a few
	function automatic int expiry_ticks();
		int load;
		load = (timeout_now == 0) ? 1 : int'(timeout_now);
		if (load > 40)
			return $urandom_range(1, 20);
		return $urandom_range((load > 1) ? load - 1 : 1, load + 1);
	endfunction

	// mostly well-formed try.snk sequences, some noise
	task automatic random_phase(input int quota, input bit hold_midway);
		int stop_at;
		int pause_at;
		int roll;
		stop_at = items_sent + quota;
		pause_at = items_sent + $urandom_range(quota / 4, 3 * quota / 4);
		while (items_sent < stop_at) begin
			if (hold_midway && items_sent >= pause_at) begin
				hold_midway = 1'b0;
				drain_results();
			end
			roll = $urandom_range(0, 19);
			if (roll < 8) begin
				// full try cycle: source seen, forced sink, timeout, try wait source
				attach(ATT_SRC);
				detach();
				tick_run(expiry_ticks());
				if ($urandom_range(0, 4) != 0)
					attach(ATT_SRC);
				detach();
			end else if (roll < 11) begin
				// sink attach with undefined kinds (5, 6, 7 and 0 after the wrap) in between
				attach(ATT_SINK);
				repeat ($urandom_range(0, 2)) attach(3'($urandom_range(5, 8)));
				detach();
			end else if (roll < 13) begin
				// audio or debug accessory, left through a sink attach
				attach(($urandom_range(0, 1) == 0) ? ATT_AUDIO : ATT_DEBUG);
				if ($urandom_range(0, 1) == 0)
					detach();
				attach(ATT_SINK);
				detach();
			end else if (roll < 15) begin
				// try abandoned: the timeout expires outside the waiting state
				attach(ATT_SRC);
				detach();
				attach(ATT_SINK);
				detach();
				tick_run(expiry_ticks());
			end else begin
				// noise
				repeat ($urandom_range(1, 4))
					send_item(1'($urandom),
						($urandom_range(0, 3) == 0) ? INT_DETACH : 8'($urandom),
						8'($urandom));
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every attach kind, ignored cases, timeout restart
		send_item(KIND_TICK, 8'hFF, 8'hFF);
		send_item(KIND_SERVICE, INT_DETACH, 8'h00);
		send_item(KIND_SERVICE, 8'h00, 8'h00);
		send_item(KIND_SERVICE, 8'hFF, 8'hFF);
		send_item(KIND_SERVICE, 8'h03, {1'b0, CUR_1500, 3'd5, 2'b10});
		send_item(KIND_SERVICE, 8'h01, {1'b0, 2'd1, 3'd6, 2'b01});
		send_item(KIND_SERVICE, 8'h80, {1'b1, CUR_1500, ATT_AUDIO, 2'b01});
		send_item(KIND_SERVICE, 8'h7F, {1'b0, CUR_3000, ATT_SRC, 2'b10});
		send_item(KIND_SERVICE, INT_DETACH, 8'hFF);
		send_item(KIND_SERVICE, 8'hFE, {1'b1, 2'd0, ATT_DEBUG, 2'b11});
		send_item(KIND_SERVICE, 8'h04, {1'b0, CUR_3000, ATT_SINK, 2'b01});
		send_item(KIND_SERVICE, 8'h06, {1'b1, CUR_1500, ATT_SRC, 2'b10});
		send_item(KIND_SERVICE, INT_DETACH, 8'h00);
		send_item(KIND_SERVICE, 8'h00, {1'b0, CUR_3000, ATT_SRC, 2'b01});
		send_item(KIND_SERVICE, INT_DETACH, 8'hAA);
		send_item(KIND_TICK, 8'h00, 8'h00);
		send_item(KIND_SERVICE, 8'h55, {1'b1, 2'd1, ATT_SINK, 2'b10});
		send_item(KIND_SERVICE, INT_DETACH, 8'h55);
		send_item(KIND_SERVICE, 8'hAA, {1'b0, CUR_1500, ATT_SRC, 2'b00});
		send_item(KIND_SERVICE, INT_DETACH, 8'h00);
		send_item(KIND_TICK, 8'hFF, 8'h00);
		send_item(KIND_TICK, INT_DETACH, 8'hFF);

		// random phases over several timeout settings, the longest last
		random_phase(PHASE_ITEMS, 1'b1);
		set_timeout(16'd1);
		random_phase(PHASE_ITEMS, 1'b0);
		set_timeout(16'd0);
		random_phase(PHASE_ITEMS, 1'b0);
		set_timeout(CFG_W'($urandom_range(2, 9)));
		random_phase(PHASE_ITEMS, 1'b0);
		set_timeout(CFG_W'($urandom_range(20, 40)));
		random_phase(PHASE_ITEMS, 1'b0);
		set_timeout(16'hFFFF);
		random_phase(PHASE_ITEMS, 1'b0);
		drain_results();

		$display("sent %0d items, checked %0d results, %0d of them port mode writes",
			items_sent, reports_seen, mode_writes_seen);
		$display("policy states reached (bit per state): %b", states_seen);
		$display("timeouts 200, 1, 0, short, mid, 65535");
		if (fail_count == 0)
			$display("typec_try_sink_policy: match");
		else
			$display("typec_try_sink_policy: mismatch");
		$finish;
	end

endmodule
